/* rtl/gbn_frame_checker_crc16_defines.svh */
// Assertion macros shared by the frame checker RTL.
`ifndef GBN_FRAME_CHECKER_CRC16_DEFINES_SVH
`define GBN_FRAME_CHECKER_CRC16_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define GFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define GFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gfc_pkg.sv */
// Types and constants for the CRC-16 frame checker.
package gfc_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Header bytes after the magic: fin, ack, seq (2), length (2).
  localparam int HDR_TAIL = 6;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_ERR   = 2'd1,
    ST_BAD_MAGIC = 2'd2,
    ST_SHORT     = 2'd3
  } gfc_status_t;

  typedef struct packed {
    logic        vld;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  fin_value;
    logic [7:0]  ack_value;
    logic [15:0] seq_number;
    logic [15:0] payload_length;
    gfc_status_t status;
  } gfc_result_t;

endpackage

/* rtl/gfc_crc8.sv */
// Augmented CRC-16 update over one byte, MSB first.
module gfc_crc8 import gfc_pkg::*; (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    logic        top;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      top = |(c & CRC_TOP);
      c   = {c[14:0], data_in[i]};
      if (top) begin
        c = c ^ CRC_POLY;
      end
    end
    crc_out = c;
  end

endmodule

/* rtl/gfc_frame_state.sv */
// Per-frame state: CRC, byte count, magic check, header capture and result build.
module gfc_frame_state import gfc_pkg::*; #(
  parameter int MAGIC_LEN = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_frame,
  input  logic [31:0] magic_word,
  output gfc_result_t res
);

  `include "gbn_frame_checker_crc16_defines.svh"

  localparam logic [15:0] MagicLen = 16'(MAGIC_LEN);
  localparam logic [15:0] HdrLen   = 16'(MAGIC_LEN + HDR_TAIL);
  localparam logic [15:0] CntMax   = 16'hFFFF;

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        match_r, match_nxt;
  logic [7:0]  fin_r, fin_nxt;
  logic [7:0]  ack_r, ack_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;

  logic [3:0][7:0] magic_bytes;
  logic            sat;
  logic [16:0]     total;
  logic [16:0]     need;
  logic [15:0]     pay_idx;

  assign magic_bytes = magic_word;
  assign sat         = (cnt_r == CntMax);
  assign cnt_nxt     = sat ? cnt_r : cnt_r + 16'd1;
  assign pay_idx     = cnt_r - HdrLen;
  assign total       = {1'b0, cnt_r} + 17'd1;
  assign need        = {1'b0, HdrLen} + {1'b0, len_nxt};

  gfc_crc8 u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_nxt)
  );

  // Header field capture by byte position.
  always_comb begin
    match_nxt = match_r;
    fin_nxt   = fin_r;
    ack_nxt   = ack_r;
    seq_nxt   = seq_r;
    len_nxt   = len_r;
    if (cnt_r < MagicLen) begin
      if (rx_byte != magic_bytes[cnt_r[1:0]]) begin
        match_nxt = 1'b0;
      end
    end else if (cnt_r == MagicLen) begin
      fin_nxt = rx_byte;
    end else if (cnt_r == MagicLen + 16'd1) begin
      ack_nxt = rx_byte;
    end else if (cnt_r == MagicLen + 16'd2) begin
      seq_nxt[7:0] = rx_byte;
    end else if (cnt_r == MagicLen + 16'd3) begin
      seq_nxt[15:8] = rx_byte;
    end else if (cnt_r == MagicLen + 16'd4) begin
      len_nxt[7:0] = rx_byte;
    end else if (cnt_r == MagicLen + 16'd5) begin
      len_nxt[15:8] = rx_byte;
    end
  end

  // Result for the current byte: summary on the final byte, else payload or nothing.
  always_comb begin
    res                = '0;
    res.fin_value      = fin_nxt;
    res.ack_value      = ack_nxt;
    res.seq_number     = seq_nxt;
    res.payload_length = len_nxt;
    res.status         = ST_OK;
    if (end_of_frame) begin
      res.vld  = 1'b1;
      res.kind = KIND_SUMMARY;
      if (crc_nxt != 16'd0) begin
        res.status = ST_CRC_ERR;
      end else if (!match_nxt) begin
        res.status = ST_BAD_MAGIC;
      end else if (!sat && (total < need)) begin
        res.status = ST_SHORT;
      end
    end else if (!sat && (cnt_r >= HdrLen) && (pay_idx < len_nxt)) begin
      res.vld           = 1'b1;
      res.kind          = KIND_PAYLOAD;
      res.payload_byte  = rx_byte;
      res.payload_index = pay_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      cnt_r   <= '0;
      match_r <= 1'b1;
      fin_r   <= '0;
      ack_r   <= '0;
      seq_r   <= '0;
      len_r   <= '0;
    end else if (step_en) begin
      if (end_of_frame) begin
        crc_r   <= CRC_INIT;
        cnt_r   <= '0;
        match_r <= 1'b1;
        fin_r   <= '0;
        ack_r   <= '0;
        seq_r   <= '0;
        len_r   <= '0;
      end else begin
        crc_r   <= crc_nxt;
        cnt_r   <= cnt_nxt;
        match_r <= match_nxt;
        fin_r   <= fin_nxt;
        ack_r   <= ack_nxt;
        seq_r   <= seq_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  `GFC_ASSERT_NEXT(a_eof_clears, step_en && end_of_frame, (cnt_r == 16'd0) && (crc_r == CRC_INIT) && match_r, "frame state not cleared after final byte")
  `GFC_ASSERT_NEXT(a_sat_holds, step_en && !end_of_frame && sat, sat, "byte count wrapped past saturation")
  `GFC_ASSERT_NOW(a_pay_in_len, res.vld && (res.kind == KIND_PAYLOAD), (res.payload_index < res.payload_length) && !sat, "payload byte beyond stated length")

endmodule

/* rtl/gbn_frame_checker_crc16.sv */
// Top level of the CRC-16 frame checker: input stage, frame logic, result register.
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+-------------
//  in      | in_rx_byte, in_end_of_frame             | in        | in_valid/in_ready
//  out     | out_kind, out_payload_*, out_*_value,   | out       | out_valid/out_ready
//          | out_seq_number, out_status              |           |
//  cfg     | cfg_wr_data                             | in        | cfg_wr_en, no wait
//
// Each item is held in the input register; the CRC byte update and the header
// position compares run between it and the result register, which takes the
// result (if any) when the input stage moves on. One item per cycle is
// sustained while out_ready stays high.
// A full result register that is not taken holds the input stage; in_ready stays
// high while the input stage is empty or can move forward in the same cycle.
// Reset (rst_n low, synchronous) clears frame state, the magic word and both
// valid flags.
module gbn_frame_checker_crc16 import gfc_pkg::*; #(
  parameter int MAGIC_LEN = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic [7:0]  out_fin_value,
  output logic [7:0]  out_ack_value,
  output logic [15:0] out_seq_number,
  output logic [15:0] out_payload_length,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  `include "gbn_frame_checker_crc16_defines.svh"

  // configuration
  logic [31:0] magic_r;

  // input stage
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_eof_r;
  logic       s1_go;

  // result register
  gfc_result_t res;
  gfc_result_t out_r;

  // Advance the input stage when the result register is free or drains now.
  assign s1_go    = s1_vld_r && (!out_r.vld || out_ready);
  assign in_ready = !s1_vld_r || s1_go;

  gfc_frame_state #(
    .MAGIC_LEN (MAGIC_LEN)
  ) u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_go),
    .rx_byte      (s1_byte_r),
    .end_of_frame (s1_eof_r),
    .magic_word   (magic_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
    end else if (cfg_wr_en) begin
      magic_r <= cfg_wr_data;
    end
  end

  // Input register: take an item whenever the stage is empty or moving on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
      s1_eof_r  <= in_end_of_frame;
    end
  end

  // Result register: load a new result, drop the old one once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else if (s1_go) begin
      out_r.vld <= res.vld;
      if (res.vld) begin
        out_r.kind           <= res.kind;
        out_r.payload_byte   <= res.payload_byte;
        out_r.payload_index  <= res.payload_index;
        out_r.fin_value      <= res.fin_value;
        out_r.ack_value      <= res.ack_value;
        out_r.seq_number     <= res.seq_number;
        out_r.payload_length <= res.payload_length;
        out_r.status         <= res.status;
      end
    end else if (out_ready) begin
      out_r.vld <= 1'b0;
    end
  end

  assign out_valid          = out_r.vld;
  assign out_kind           = out_r.kind;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_payload_index  = out_r.payload_index;
  assign out_fin_value      = out_r.fin_value;
  assign out_ack_value      = out_r.ack_value;
  assign out_seq_number     = out_r.seq_number;
  assign out_payload_length = out_r.payload_length;
  assign out_status         = out_r.status;

  `GFC_ASSERT_NOW(a_pay_status_ok, out_valid && (out_kind == KIND_PAYLOAD),
                  out_r.status == ST_OK, "payload result with nonzero status")
  `GFC_ASSERT_NOW(a_sum_no_payload, out_valid && (out_kind == KIND_SUMMARY),
                  (out_payload_byte == 8'd0) && (out_payload_index == 16'd0),
                  "summary carries payload data")
  `GFC_ASSERT_NEXT(a_s1_holds, s1_vld_r && out_valid && !out_ready,
                   s1_vld_r && $stable(s1_byte_r) && $stable(s1_eof_r),
                   "input stage lost an item under stall")

endmodule
